// ----- design/lfu_pkg.sv -----
// shared types and constants for the lfu replacement policy block
// request/response payloads, command and status structs, state encoding
// no dependencies
package lfu_pkg;

  localparam int ENTRIES     = 64;
  localparam int COUNT_WIDTH = 16;
  localparam int KEY_W       = 32;
  localparam int IDX_W       = $clog2(ENTRIES);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_ACCESS = 2'd1;
  localparam logic [1:0] REQ_EVICT  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_DUP    = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] victim_key;
    logic                    victim_valid;
    logic [2:0]              status;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic [COUNT_WIDTH-1:0] count;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_COMMIT
  } state_t;

endpackage

// ----- design/lfu_ctrl.sv -----
// controller state machine for the lfu replacement policy block
// sequences request load, table scan and commit; owns response valid
// depends on lfu_pkg
module lfu_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  lfu_pkg::sts_t sts,
  output lfu_pkg::cmd_t cmd
);
  import lfu_pkg::*;

  state_t state, state_next;
  logic   rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    req_ready      = 1'b0;
    cmd            = '0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last) begin
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // wait for the response register to free up
        if (!rsp_valid || rsp_ready) begin
          cmd.commit     = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/lfu_dp.sv -----
// datapath for the lfu replacement policy block
// entry memory, valid bits, scan counter, match/free/minimum trackers, response register
// depends on lfu_pkg
module lfu_dp (
  input  logic          clk,
  input  logic          rst,
  input  lfu_pkg::cmd_t cmd,
  output lfu_pkg::sts_t sts,
  input  lfu_pkg::req_t req,
  output lfu_pkg::rsp_t rsp
);
  import lfu_pkg::*;

  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] valid;

  req_t               req_q;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   rd_idx;
  logic               rd_pend;
  entry_t             rd_word;
  logic               rd_valid;

  logic                    hit;
  logic [IDX_W-1:0]        hit_idx;
  logic [COUNT_WIDTH-1:0]  hit_cnt;
  logic                    free_found;
  logic [IDX_W-1:0]        free_idx;
  logic                    min_found;
  logic [IDX_W-1:0]        min_idx;
  logic [COUNT_WIDTH-1:0]  min_cnt;
  logic signed [KEY_W-1:0] min_key;

  logic                    we;
  logic [IDX_W-1:0]        wa;
  entry_t                  wd;
  logic                    set_valid;
  logic                    clr_valid;
  rsp_t                    rsp_next;

  logic is_match;
  logic is_free;
  logic is_min;

  assign sts.last = (idx == IDX_W'(ENTRIES - 1));

  // scan counter and read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
      idx   <= '0;
    end else if (cmd.scan) begin
      idx <= idx + 1'b1;
    end
    rd_idx <= idx;
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.scan) begin
      rd_word  <= mem[idx];
      rd_valid <= valid[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (set_valid) begin
      valid[wa] <= 1'b1;
    end else if (clr_valid) begin
      valid[min_idx] <= 1'b0;
    end
  end

  // per entry compare
  always_comb begin
    is_match = rd_valid && (rd_word.key == req_q.key);
    is_free  = !rd_valid;
    is_min   = rd_valid && (!min_found || (rd_word.count < min_cnt) ||
               ((rd_word.count == min_cnt) && ($signed(rd_word.key) < min_key)));
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      hit        <= 1'b0;
      free_found <= 1'b0;
      min_found  <= 1'b0;
    end else if (rd_pend) begin
      if (is_match && !hit) begin
        hit <= 1'b1;
      end
      if (is_free && !free_found) begin
        free_found <= 1'b1;
      end
      if (is_min) begin
        min_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      if (is_match && !hit) begin
        hit_idx <= rd_idx;
        hit_cnt <= rd_word.count;
      end
      if (is_free && !free_found) begin
        free_idx <= rd_idx;
      end
      if (is_min) begin
        min_idx <= rd_idx;
        min_cnt <= rd_word.count;
        min_key <= $signed(rd_word.key);
      end
    end
  end

  // commit decision
  always_comb begin
    we        = 1'b0;
    wa        = free_idx;
    wd        = '0;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    rsp_next  = '0;
    if (cmd.commit) begin
      case (req_q.req_type)
        REQ_ADD: begin
          if (hit) begin
            rsp_next.status = ST_DUP;
          end else if (!free_found) begin
            rsp_next.status = ST_FULL;
          end else begin
            we        = 1'b1;
            set_valid = 1'b1;
            wd.key    = req_q.key;
            wd.count  = CNT_ONE;
          end
        end
        REQ_ACCESS: begin
          wa = hit_idx;
          if (!hit) begin
            rsp_next.status = ST_ABSENT;
          end else if (hit_cnt != CNT_MAX) begin
            we       = 1'b1;
            wd.key   = req_q.key;
            wd.count = hit_cnt + 1'b1;
          end
        end
        REQ_EVICT: begin
          if (!min_found) begin
            rsp_next.status = ST_EMPTY;
          end else begin
            clr_valid             = 1'b1;
            rsp_next.victim_key   = min_key;
            rsp_next.victim_valid = 1'b1;
          end
        end
        default: begin
          rsp_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- design/lfu_replacement_policy_top.sv -----
// top level of the lfu replacement policy block
// channel   | handshake             | payload
// request   | req_valid / req_ready | req  (req_type, key)
// response  | rsp_valid / rsp_ready | rsp  (victim_key, victim_valid, status)
// a request is accepted, then the entry memory is read once per entry in turn, a
// last state lets the final read reach the trackers, then the result is committed
// into the response register; reset clears the valid bits and flags, not the memory
// a stalled response holds commit; a new request is taken while a response waits
// depends on lfu_pkg, lfu_ctrl, lfu_dp
module lfu_replacement_policy_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lfu_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output lfu_pkg::rsp_t rsp
);
  import lfu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfu_dp u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts),
    .req (req),
    .rsp (rsp)
  );

endmodule

// ----- design/lfu_chk.sv -----
// port level checks for the lfu replacement policy block
// bound to lfu_replacement_policy_top; depends on lfu_pkg
module lfu_chk (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input lfu_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input lfu_pkg::rsp_t rsp
);
  import lfu_pkg::*;

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // a victim only comes with ok status
  a_victim_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.victim_valid |-> rsp.status == ST_OK)
    else $error("victim with error status");

  // no victim key without a victim
  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.victim_valid |-> rsp.victim_key == '0)
    else $error("victim key without victim");

  // status stays within its codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status == ST_OK || rsp.status == ST_FULL || rsp.status == ST_DUP ||
                  rsp.status == ST_ABSENT || rsp.status == ST_EMPTY)
    else $error("unknown status code");

endmodule

bind lfu_replacement_policy_top lfu_chk u_chk (.*);
